// ===== hdl/imuma_pkg.sv =====
package imuma_pkg;

  localparam int CHANNELS   = 6;
  localparam int SAMPLE_W   = 16;
  localparam int TAG_W      = 32;
  localparam int WINDOW_DEF = 5;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef sample_t [CHANNELS-1:0] sample_vec_t;

  // handover from the accumulator stage to the divide stages
  typedef struct packed {
    logic valid;
    logic averaged;
  } s1_ctrl_t;

endpackage

// ===== hdl/imuma_hist.sv =====
module imuma_hist #(
  parameter int WINDOW = imuma_pkg::WINDOW_DEF,
  parameter int PTR_W  = $clog2(WINDOW)
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [PTR_W-1:0]        wr_addr,
  input  imuma_pkg::sample_vec_t  wr_data,
  input  logic [PTR_W-1:0]        rd_addr,
  output imuma_pkg::sample_vec_t  rd_data
);

  imuma_pkg::sample_vec_t mem [WINDOW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/imuma_accum.sv =====
module imuma_accum #(
  parameter int WINDOW = imuma_pkg::WINDOW_DEF,
  parameter int SUM_W  = imuma_pkg::SAMPLE_W + $clog2(WINDOW),
  parameter int PTR_W  = $clog2(WINDOW)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  imuma_pkg::sample_vec_t        samples,
  input  logic [imuma_pkg::TAG_W-1:0]   tag,
  // history memory
  output logic                          hist_wr_en,
  output logic [PTR_W-1:0]              hist_wr_addr,
  output imuma_pkg::sample_vec_t        hist_wr_data,
  output logic [PTR_W-1:0]              hist_rd_addr,
  input  imuma_pkg::sample_vec_t        hist_rd,
  // towards the divider
  output imuma_pkg::s1_ctrl_t           s1_ctrl,
  input  logic                          s1_take,
  output logic signed [SUM_W-1:0]       sums [imuma_pkg::CHANNELS],
  output imuma_pkg::sample_vec_t        s1_samples,
  output logic [imuma_pkg::TAG_W-1:0]   s1_tag
);

  localparam int SW = imuma_pkg::SAMPLE_W;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(WINDOW - 1);

  logic             accept;
  logic [PTR_W-1:0] slot;
  logic [PTR_W-1:0] slot_next;
  logic             full;

  logic signed [SW-1:0]    old [imuma_pkg::CHANNELS];
  logic signed [SW:0]      delta [imuma_pkg::CHANNELS];
  logic signed [SUM_W-1:0] sums_next [imuma_pkg::CHANNELS];

  // no word is taken while reset is held
  assign in_ready  = !rst && (!s1_ctrl.valid || s1_take);
  assign accept    = in_valid && in_ready;
  assign slot_next = (slot == LAST) ? '0 : slot + 1'b1;

  assign hist_wr_en   = accept;
  assign hist_wr_addr = slot;
  assign hist_wr_data = samples;
  // look one slot ahead so the oldest word is registered before it is needed
  assign hist_rd_addr = accept ? slot_next : slot;

  always_comb begin
    for (int c = 0; c < imuma_pkg::CHANNELS; c++) begin
      old[c]       = full ? $signed(hist_rd[c]) : '0;
      delta[c]     = (SW + 1)'($signed(samples[c])) - (SW + 1)'(old[c]);
      sums_next[c] = sums[c] + SUM_W'(delta[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot          <= '0;
      full          <= 1'b0;
      s1_ctrl.valid <= 1'b0;
      for (int c = 0; c < imuma_pkg::CHANNELS; c++) begin
        sums[c] <= '0;
      end
    end else begin
      if (accept) begin
        slot             <= slot_next;
        full             <= full || (slot == LAST);
        s1_ctrl.valid    <= 1'b1;
        s1_ctrl.averaged <= full || (slot == LAST);
        s1_samples       <= samples;
        s1_tag           <= tag;
        for (int c = 0; c < imuma_pkg::CHANNELS; c++) begin
          sums[c] <= sums_next[c];
        end
      end else if (s1_take) begin
        s1_ctrl.valid <= 1'b0;
      end
    end
  end

  a_accept_loads : assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_ctrl.valid)
    else $error("accepted word not held in accumulator stage");

  a_full_avg : assert property (@(posedge clk) disable iff (rst)
    accept && full |=> s1_ctrl.averaged && full)
    else $error("average flag lost after window filled");

  a_fill_wrap : assert property (@(posedge clk) disable iff (rst)
    accept && !full && (slot == LAST) |=> full && (slot == '0) && s1_ctrl.averaged)
    else $error("window completion did not wrap slot pointer");

endmodule

// ===== hdl/imuma_div.sv =====
module imuma_div #(
  parameter int WINDOW = imuma_pkg::WINDOW_DEF,
  parameter int SUM_W  = imuma_pkg::SAMPLE_W + $clog2(WINDOW)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  imuma_pkg::s1_ctrl_t           in_ctrl,
  output logic                          ready,
  input  logic signed [SUM_W-1:0]       sums [imuma_pkg::CHANNELS],
  input  imuma_pkg::sample_vec_t        samples,
  input  logic [imuma_pkg::TAG_W-1:0]   tag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output imuma_pkg::sample_vec_t        out_data,
  output logic [imuma_pkg::TAG_W-1:0]   out_tag,
  output logic                          averaged
);

  localparam int SW      = imuma_pkg::SAMPLE_W;
  localparam int LOG_W   = $clog2(WINDOW);
  localparam int SHIFT   = SUM_W + LOG_W;
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam int QW      = SW + 1;
  // ceil(2^SHIFT / WINDOW): exact floor quotient for any SUM_W-bit magnitude
  localparam longint unsigned RECIP_FULL =
    ((longint'(1) << SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

  logic out_take;
  logic s2_take;

  logic                          s2_valid;
  logic                          s2_avg;
  logic [imuma_pkg::CHANNELS-1:0] s2_neg;
  logic [PROD_W-1:0]             s2_prod [imuma_pkg::CHANNELS];
  imuma_pkg::sample_vec_t        s2_samp;
  logic [imuma_pkg::TAG_W-1:0]   s2_tag;

  logic [SUM_W-1:0]  mag [imuma_pkg::CHANNELS];
  logic [PROD_W-1:0] prod_next [imuma_pkg::CHANNELS];
  logic [QW-1:0]     qmag [imuma_pkg::CHANNELS];
  logic [QW-1:0]     qsgn [imuma_pkg::CHANNELS];
  imuma_pkg::sample_vec_t res;

  assign out_take = !out_valid || out_ready;
  assign s2_take  = !s2_valid || out_take;
  assign ready    = s2_take;

  always_comb begin
    for (int c = 0; c < imuma_pkg::CHANNELS; c++) begin
      mag[c]       = sums[c][SUM_W-1] ? SUM_W'(-sums[c]) : SUM_W'(sums[c]);
      prod_next[c] = PROD_W'(mag[c]) * PROD_W'(RECIP);
    end
  end

  always_comb begin
    for (int c = 0; c < imuma_pkg::CHANNELS; c++) begin
      qmag[c] = QW'(s2_prod[c] >> SHIFT);
      qsgn[c] = s2_neg[c] ? -qmag[c] : qmag[c];
      res[c]  = s2_avg ? qsgn[c][SW-1:0] : s2_samp[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s2_take) begin
        s2_valid <= in_ctrl.valid;
        s2_avg   <= in_ctrl.averaged;
        s2_samp  <= samples;
        s2_tag   <= tag;
        for (int c = 0; c < imuma_pkg::CHANNELS; c++) begin
          s2_neg[c]  <= sums[c][SUM_W-1];
          s2_prod[c] <= prod_next[c];
        end
      end
      if (out_take) begin
        out_valid <= s2_valid;
        out_data  <= res;
        out_tag   <= s2_tag;
        averaged  <= s2_avg;
      end
    end
  end

  a_s2_hold : assert property (@(posedge clk) disable iff (rst)
    s2_valid && !out_take |=> s2_valid && $stable(s2_tag))
    else $error("product stage dropped a word under stall");

  a_s2_load : assert property (@(posedge clk) disable iff (rst)
    in_ctrl.valid && ready |=> s2_valid)
    else $error("word from accumulator not taken into product stage");

endmodule

// ===== hdl/imu_six_channel_moving_average.sv =====
// Six-channel IMU moving average.
// Input channel: in_valid/in_ready with accel_x/y/z, gyro_x/y/z (signed 16 bit)
// and sample_tag; output channel: out_valid/out_ready with the six filtered
// channels, out_tag and averaged. A word is taken when valid and ready are high.
// Samples 1 .. WINDOW-1 after reset pass through with averaged low; from the
// WINDOW-th on each channel gives the window sum divided by WINDOW, truncated
// toward zero, with averaged high.
// A word passes three pipeline registers: running sums, reciprocal product,
// result. Throughput: one word per cycle while the receiver does not stall;
// the history memory is read one slot ahead through its registered port, so
// the oldest sample is ready every cycle.
// Reset clears the running sums, the fill state and all stage valids; the
// history memory is not cleared and is only used once the window has filled.
// When the receiver stalls the result is held and the earlier stages keep
// taking words until all three stages are occupied.
module imu_six_channel_moving_average #(
  parameter int WINDOW = imuma_pkg::WINDOW_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [imuma_pkg::SAMPLE_W-1:0] accel_x,
  input  logic signed [imuma_pkg::SAMPLE_W-1:0] accel_y,
  input  logic signed [imuma_pkg::SAMPLE_W-1:0] accel_z,
  input  logic signed [imuma_pkg::SAMPLE_W-1:0] gyro_x,
  input  logic signed [imuma_pkg::SAMPLE_W-1:0] gyro_y,
  input  logic signed [imuma_pkg::SAMPLE_W-1:0] gyro_z,
  input  logic [imuma_pkg::TAG_W-1:0]          sample_tag,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [imuma_pkg::SAMPLE_W-1:0] out_accel_x,
  output logic signed [imuma_pkg::SAMPLE_W-1:0] out_accel_y,
  output logic signed [imuma_pkg::SAMPLE_W-1:0] out_accel_z,
  output logic signed [imuma_pkg::SAMPLE_W-1:0] out_gyro_x,
  output logic signed [imuma_pkg::SAMPLE_W-1:0] out_gyro_y,
  output logic signed [imuma_pkg::SAMPLE_W-1:0] out_gyro_z,
  output logic [imuma_pkg::TAG_W-1:0]          out_tag,
  output logic                                 averaged
);

  localparam int SUM_W = imuma_pkg::SAMPLE_W + $clog2(WINDOW);
  localparam int PTR_W = $clog2(WINDOW);

  imuma_pkg::sample_vec_t in_vec;
  imuma_pkg::sample_vec_t out_vec;

  logic                        hist_wr_en;
  logic [PTR_W-1:0]            hist_wr_addr;
  imuma_pkg::sample_vec_t      hist_wr_data;
  logic [PTR_W-1:0]            hist_rd_addr;
  imuma_pkg::sample_vec_t      hist_rd;

  imuma_pkg::s1_ctrl_t         s1_ctrl;
  logic                        s1_take;
  logic signed [SUM_W-1:0]     sums [imuma_pkg::CHANNELS];
  imuma_pkg::sample_vec_t      s1_samples;
  logic [imuma_pkg::TAG_W-1:0] s1_tag;

  assign in_vec[0] = accel_x;
  assign in_vec[1] = accel_y;
  assign in_vec[2] = accel_z;
  assign in_vec[3] = gyro_x;
  assign in_vec[4] = gyro_y;
  assign in_vec[5] = gyro_z;

  assign out_accel_x = $signed(out_vec[0]);
  assign out_accel_y = $signed(out_vec[1]);
  assign out_accel_z = $signed(out_vec[2]);
  assign out_gyro_x  = $signed(out_vec[3]);
  assign out_gyro_y  = $signed(out_vec[4]);
  assign out_gyro_z  = $signed(out_vec[5]);

  imuma_hist #(
    .WINDOW (WINDOW),
    .PTR_W  (PTR_W)
  ) u_hist (
    .clk     (clk),
    .wr_en   (hist_wr_en),
    .wr_addr (hist_wr_addr),
    .wr_data (hist_wr_data),
    .rd_addr (hist_rd_addr),
    .rd_data (hist_rd)
  );

  imuma_accum #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W),
    .PTR_W  (PTR_W)
  ) u_accum (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .samples      (in_vec),
    .tag          (sample_tag),
    .hist_wr_en   (hist_wr_en),
    .hist_wr_addr (hist_wr_addr),
    .hist_wr_data (hist_wr_data),
    .hist_rd_addr (hist_rd_addr),
    .hist_rd      (hist_rd),
    .s1_ctrl      (s1_ctrl),
    .s1_take      (s1_take),
    .sums         (sums),
    .s1_samples   (s1_samples),
    .s1_tag       (s1_tag)
  );

  imuma_div #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_ctrl   (s1_ctrl),
    .ready     (s1_take),
    .sums      (sums),
    .samples   (s1_samples),
    .tag       (s1_tag),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_vec),
    .out_tag   (out_tag),
    .averaged  (averaged)
  );

endmodule
